// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the hash set.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/lphs_pkg.sv -----
// Package of the linear probe hash set: widths, codes and beat types.
// Used by the top level, lphs_rem and lphs_checker; depends on nothing.
package lphs_pkg;

   localparam int KEY_W     = 31;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 10;
   localparam int OCC_W     = 11;
   localparam int CSR_W     = 11;
   localparam int TAG_W     = 2;
   localparam int DEPTH_DEF = 1024;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   // Slot tags.
   localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
   localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
   localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [OCC_W-1:0]    occupied;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage

// ----- src/linear_probe_hash_set.sv -----
// Top level of the linear probe hash set: probe sequencer, slot store and count.
// Depends on lphs_pkg, lphs_ram and lphs_rem.
//
//  Channel    Ports                       Handshake
//  request    start, busy, req_data       beat taken when start is high and busy low
//  response   rsp_valid, rsp_data         one-cycle strobe, cannot be held off
//  csr        csr_wr_en, csr_wr_data      written on any edge with csr_wr_en high
//
// After reset the block sweeps the slot store to empty, one slot a cycle, with
// busy high. An insert into a full table and an unused command answer in the
// cycle after the request beat. Every other command first forms the home slot in
// the bit-serial remainder unit and then probes slots, from one up to the
// capacity in use; each probe is one read of the slot RAM. One item is in flight
// at a time; for a probing command busy stays high until its response strobe.
module linear_probe_hash_set #(
   parameter int DEPTH = lphs_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lphs_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output lphs_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [lphs_pkg::CSR_W-1:0]    csr_wr_data
);

   // Slot index width, live count width, and a common width for capacity math
   // that holds both the register value and DEPTH itself.
   localparam int IW     = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = (CNT_W > lphs_pkg::CSR_W) ? CNT_W : lphs_pkg::CSR_W;
   localparam int SLOT_X = (IW > lphs_pkg::SLOT_W) ? IW : lphs_pkg::SLOT_W;
   localparam int ENTRY_W = $bits(lphs_pkg::entry_type);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_PROBE
   } state_type;

   state_type                     state_ff, state_in;
   logic [IW-1:0]                 clr_ff, clr_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic [CAP_W-1:0]              sweep_ff, sweep_in;
   logic [CAP_W-1:0]              cap_ff, cap_in;
   logic [lphs_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [lphs_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]              live_ff, live_in;
   logic [lphs_pkg::CSR_W-1:0]    csr_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   lphs_pkg::rsp_type             rsp_ff, rsp_in;

   // Capacity as the hash sees it: zero acts as one, anything above DEPTH as DEPTH.
   logic [CAP_W-1:0]              cap_now;
   logic [CAP_W-1:0]              csr_ext;
   logic [CAP_W-1:0]              live_ext;
   logic [CAP_W-1:0]              idx_p1;
   logic [CAP_W-1:0]              sweep_p1;
   logic [IW-1:0]                 idx_next;
   logic [SLOT_X-1:0]             slot_ext;
   logic [CAP_W-1:0]              occ_ext;

   logic                          rem_start;
   logic                          rem_done;
   logic [CAP_W-1:0]              rem_value;

   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   lphs_pkg::entry_type           wr_entry;
   lphs_pkg::entry_type           rd_entry;
   logic [ENTRY_W-1:0]            rd_word;

   logic                          is_insert;
   logic                          hit_key;
   logic                          hit_free;
   logic                          hit_empty;

   assign csr_ext  = CAP_W'(csr_ff);
   assign live_ext = CAP_W'(live_ff);

   always_comb begin
      cap_now = csr_ext;
      if (csr_ext == '0) begin
         cap_now = CAP_W'(1);
      end else if (csr_ext > CAP_W'(DEPTH)) begin
         cap_now = CAP_W'(DEPTH);
      end
   end

   // Next slot in the probe sequence, wrapping at the capacity in use.
   assign idx_p1   = CAP_W'(idx_ff) + CAP_W'(1);
   assign idx_next = (idx_p1 >= cap_ff) ? '0 : idx_p1[IW-1:0];
   assign sweep_p1 = sweep_ff + CAP_W'(1);

   // Slot classification for the entry read in the previous cycle. All commands stop
   // at a live slot with the key; insert also on any non-live slot, others on empty.
   assign rd_entry  = rd_word;
   assign is_insert = (cmd_ff == lphs_pkg::CMD_INSERT);
   assign hit_key   = (rd_entry.tag == lphs_pkg::TAG_LIVE) && (rd_entry.key == key_ff);
   assign hit_free  = is_insert && (rd_entry.tag != lphs_pkg::TAG_LIVE);
   assign hit_empty = !is_insert && (rd_entry.tag == lphs_pkg::TAG_EMPTY);

   assign slot_ext = SLOT_X'(idx_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      sweep_in     = sweep_ff;
      cap_in       = cap_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      live_in      = live_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rem_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_entry     = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clr_ff;
            wr_entry.tag = lphs_pkg::TAG_EMPTY;
            if (clr_ff == IW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = req_data.cmd;
               key_in = req_data.key;
               cap_in = cap_now;
               case (req_data.cmd)
                  lphs_pkg::CMD_INSERT: begin
                     if (live_ext >= cap_now) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lphs_pkg::ST_FULL;
                        rsp_in.slot   = '0;
                     end else begin
                        rem_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  lphs_pkg::CMD_REMOVE, lphs_pkg::CMD_SEARCH: begin
                     rem_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = lphs_pkg::ST_MISSING;
                     rsp_in.slot   = '0;
                  end
               endcase
            end
         end
         S_DIV: begin
            // The home slot goes straight to the RAM read address.
            if (rem_done) begin
               idx_in   = rem_value[IW-1:0];
               sweep_in = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (hit_key) begin
               rsp_valid_in = 1'b1;
               rsp_in.slot  = slot_ext[lphs_pkg::SLOT_W-1:0];
               state_in     = S_IDLE;
               if (is_insert) begin
                  rsp_in.status = lphs_pkg::ST_PRESENT;
               end else begin
                  rsp_in.status = lphs_pkg::ST_OK;
                  if (cmd_ff == lphs_pkg::CMD_REMOVE) begin
                     wr_en        = 1'b1;
                     wr_entry.tag = lphs_pkg::TAG_TOMB;
                     wr_entry.key = key_ff;
                     if (live_ff != '0) begin
                        live_in = live_ff - 1'b1;
                     end
                  end
               end
            end else if (hit_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = lphs_pkg::ST_OK;
               rsp_in.slot   = slot_ext[lphs_pkg::SLOT_W-1:0];
               state_in      = S_IDLE;
               wr_en         = 1'b1;
               wr_entry.tag  = lphs_pkg::TAG_LIVE;
               wr_entry.key  = key_ff;
               if (live_ext < CAP_W'(DEPTH)) begin
                  live_in = live_ff + 1'b1;
               end
            end else if (hit_empty || (sweep_p1 >= cap_ff)) begin
               // Empty slot for remove or search, or a full sweep without a stop.
               rsp_valid_in  = 1'b1;
               rsp_in.status = lphs_pkg::ST_MISSING;
               rsp_in.slot   = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in   = idx_next;
               sweep_in = sweep_p1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The reported count is the one after this operation.
      occ_ext         = CAP_W'(live_in);
      rsp_in.occupied = occ_ext[lphs_pkg::OCC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         csr_ff       <= lphs_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
      idx_ff   <= idx_in;
      sweep_ff <= sweep_in;
      cap_ff   <= cap_in;
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      rsp_ff   <= rsp_in;
   end

   lphs_rem #(
      .DIV_W (CAP_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_data.key),
      .divisor   (cap_now),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // The read address is the next probe index, so the entry for idx_ff is on the
   // read data while idx_ff holds it. Apart from the reset sweep, writes happen only
   // at the end of an item, before the next item's first read.
   lphs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx_in),
      .rd_data (rd_word)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/lphs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lphs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lphs_rem.sv -----
// Bit-serial remainder unit: key modulo a run-time divisor, one bit per cycle.
// Depends on lphs_pkg for the key width.
module lphs_rem #(
   parameter int DIV_W = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [lphs_pkg::KEY_W-1:0] dividend,
   input  logic [DIV_W-1:0]         divisor,
   output logic                     done,
   output logic [DIV_W-1:0]         remainder
);

   localparam int KW    = lphs_pkg::KEY_W;
   localparam int CNT_W = $clog2(KW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [KW-1:0]    num_ff, num_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;

   assign trial = {rem_ff, num_ff[KW-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(KW - 1);
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits DIV_W bits.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIV_W-1:0];
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         num_in = {num_ff[KW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/lphs_checker.sv -----
// Port-level checker of the linear probe hash set, bound to the top level.
// Depends on lphs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lphs_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input lphs_pkg::req_type req_data,
   input logic              rsp_valid,
   input lphs_pkg::rsp_type rsp_data,
   input logic              csr_wr_en
);

   logic take_beat;
   logic probe_cmd;
   logic miss_rsp;

   assign take_beat = start && !busy;
   assign probe_cmd = (req_data.cmd == lphs_pkg::CMD_REMOVE) ||
                      (req_data.cmd == lphs_pkg::CMD_SEARCH);
   assign miss_rsp  = rsp_valid && ((rsp_data.status == lphs_pkg::ST_MISSING) ||
                                    (rsp_data.status == lphs_pkg::ST_FULL));

   // An accepted remove or search beat keeps the block busy in the next cycle.
   `ASSERT_NEXT(a_probe_busy, clock, reset, take_beat && probe_cmd, busy, "probe left busy low")

   // A response beat closes its item, so the block is ready again while it shows.
   `ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "busy during response")

   // A response always follows a cycle in which an item was taken or in flight.
   `ASSERT_SAME(a_cause, clock, reset, rsp_valid, $past(busy || start), "stray response")

   // Misses and refusals report slot zero.
   `ASSERT_SAME(a_slot_zero, clock, reset, miss_rsp, rsp_data.slot == '0, "slot on miss")

   // The capacity register must only change while no item is pending or in flight; the block does not enforce it.
   `ASSERT_SAME(a_csr_idle, clock, reset, csr_wr_en, !busy && !start, "write in flight")

endmodule

bind linear_probe_hash_set lphs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_wr_en (csr_wr_en)
);
